/* rtl/pps_pkg.sv */
package pps_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic REQ_ARRIVAL  = 1'b0;
	localparam logic REQ_COMPLETE = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] timestamp;
		logic [15:0] new_pid;
		logic [31:0] new_arrival;
		logic [15:0] new_total_burst;
		logic [7:0]  new_priority;
	} req_t;

	typedef struct packed {
		logic        run_valid;
		logic [15:0] run_pid;
		logic [31:0] run_arrival;
		logic [15:0] run_total_burst;
		logic [31:0] run_start;
		logic [31:0] run_end;
		logic [15:0] run_remaining;
		logic [7:0]  run_priority;
		logic [4:0]  queue_count;
		logic        dropped;
	} rsp_t;

	// one ready-queue record
	typedef struct packed {
		logic [15:0] pid;
		logic [31:0] arrival;
		logic [15:0] total;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/pps_if.sv */
interface pps_req_if;
	logic           valid;
	logic           ready;
	pps_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pps_rsp_if;
	logic           valid;
	logic           ready;
	pps_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pps_ram.sv */
module pps_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* rtl/preemptive_priority_scheduler.sv */
// channel | dir | payload
// req     | in  | req_type, timestamp, new_pid, new_arrival, new_total_burst, new_priority
// rsp     | out | run_* fields, queue_count, dropped
//
// Arrival: decide and queue write in the accepting cycle, then the response.
// Completion: accept, a scan for the best priority through the queue RAM's single read
// port, a pick state, compaction of the entries behind the picked one, then the
// response.
// Reset clears the running record and the count; the RAM needs no clearing.
// A stalled response holds the block; the next request waits for it to leave.
module preemptive_priority_scheduler (
	input logic clk,
	input logic arst_n,
	pps_req_if.sink   req,
	pps_rsp_if.source rsp
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_PICK  = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam int IW = pps_pkg::IDX_W;
	localparam int CW = pps_pkg::CNT_W;

	logic [2:0] state_q;
	pps_pkg::req_t req_q;
	logic          cur_valid_q;
	pps_pkg::entry_t cur_q;
	logic [31:0]   cur_start_q;
	logic [CW-1:0] count_q;
	logic          dropped_q;

	logic [CW-1:0] rd_q;      // next read index
	logic [CW-1:0] seen_q;    // entries whose data has come back
	logic [IW-1:0] best_q;
	pps_pkg::entry_t best_ent_q;
	logic          have_best_q;
	logic [CW-1:0] wr_q;      // compaction write index

	logic                 we;
	logic [IW-1:0]        waddr;
	pps_pkg::entry_t      wdata;
	logic [IW-1:0]        raddr;
	logic [pps_pkg::ENTRY_W-1:0] rdata;
	pps_pkg::entry_t      rent;

	pps_ram #(.DEPTH(pps_pkg::QUEUE_DEPTH), .WIDTH(pps_pkg::ENTRY_W)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);
	assign rent = pps_pkg::entry_t'(rdata);

	logic        room;
	logic [31:0] elapsed;
	logic [15:0] rem_left;
	assign room     = count_q < CW'(pps_pkg::QUEUE_DEPTH);
	assign elapsed  = req.data.timestamp - cur_start_q;
	assign rem_left = ({16'd0, cur_q.remaining} > elapsed) ?
		cur_q.remaining - elapsed[15:0] : 16'd0;

	assign req.ready = (state_q == ST_IDLE);
	assign raddr     = rd_q[IW-1:0];

	// queue write: append on arrival, move down during compaction
	always_comb begin
		we    = 1'b0;
		waddr = count_q[IW-1:0];
		wdata = '{pid: req.data.new_pid, arrival: req.data.new_arrival,
			total: req.data.new_total_burst, remaining: req.data.new_total_burst,
			prio: req.data.new_priority};
		if (state_q == ST_IDLE && req.valid && req.data.req_type == pps_pkg::REQ_ARRIVAL
				&& cur_valid_q && room) begin
			we = 1'b1;
			if (req.data.new_priority < cur_q.prio)
				wdata = '{pid: cur_q.pid, arrival: cur_q.arrival, total: cur_q.total,
					remaining: rem_left, prio: cur_q.prio};
		end else if (state_q == ST_SHIFT && seen_q != rd_q) begin
			we    = 1'b1;
			waddr = wr_q[IW-1:0];
			wdata = rent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			cur_start_q <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			rd_q        <= '0;
			seen_q      <= '0;
			wr_q        <= '0;
			best_q      <= '0;
			best_ent_q  <= '0;
			have_best_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (req.valid) begin
					req_q     <= req.data;
					dropped_q <= 1'b0;
					if (req.data.req_type == pps_pkg::REQ_ARRIVAL) begin
						if (!cur_valid_q || req.data.new_priority < cur_q.prio) begin
							cur_valid_q <= 1'b1;
							cur_q <= '{pid: req.data.new_pid, arrival: req.data.new_arrival,
								total: req.data.new_total_burst,
								remaining: req.data.new_total_burst,
								prio: req.data.new_priority};
							cur_start_q <= req.data.timestamp;
						end
						if (cur_valid_q) begin
							if (room) count_q <= count_q + 1'b1;
							else dropped_q <= 1'b1;
						end
						state_q <= ST_OUT;
					end else if (count_q == '0) begin
						cur_valid_q <= 1'b0;
						cur_q       <= '0;
						cur_start_q <= '0;
						state_q     <= ST_OUT;
					end else begin
						rd_q        <= '0;
						seen_q      <= '0;
						have_best_q <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				// rd_q leads seen_q by one: the RAM answers in the cycle after the read
				ST_SCAN: begin
					if (rd_q != seen_q) begin
						if (!have_best_q || rent.prio < best_ent_q.prio) begin
							best_q     <= seen_q[IW-1:0];
							best_ent_q <= rent;
						end
						have_best_q <= 1'b1;
						seen_q <= seen_q + 1'b1;
					end
					if (rd_q < count_q) rd_q <= rd_q + 1'b1;
					else if (rd_q == seen_q + 1'b1) state_q <= ST_PICK;
				end
				ST_PICK: begin
					cur_valid_q <= 1'b1;
					cur_q       <= best_ent_q;
					cur_start_q <= req_q.timestamp;
					wr_q        <= {1'b0, best_q};
					rd_q        <= {1'b0, best_q} + 1'b1;
					seen_q      <= {1'b0, best_q} + 1'b1;
					state_q     <= ST_SHIFT;
				end
				// entry i+1 read, written to i in the cycle after
				ST_SHIFT: begin
					if (seen_q != rd_q) begin
						wr_q   <= wr_q + 1'b1;
						seen_q <= seen_q + 1'b1;
					end
					if (rd_q < count_q) rd_q <= rd_q + 1'b1;
					else if (seen_q == rd_q || seen_q + 1'b1 == rd_q) begin
						if (seen_q + 1'b1 == rd_q || seen_q == count_q) begin
							count_q <= count_q - 1'b1;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: if (rsp.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = (state_q == ST_OUT);
	always_comb begin
		rsp.data.run_valid       = cur_valid_q;
		rsp.data.run_pid         = cur_q.pid;
		rsp.data.run_arrival     = cur_q.arrival;
		rsp.data.run_total_burst = cur_q.total;
		rsp.data.run_start       = cur_start_q;
		rsp.data.run_end         = cur_start_q + {16'd0, cur_q.remaining};
		rsp.data.run_remaining   = cur_q.remaining;
		rsp.data.run_priority    = cur_q.prio;
		rsp.data.queue_count     = 5'(count_q);
		rsp.data.dropped         = dropped_q;
	end

endmodule

/* rtl/pps_checker.sv */
module pps_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input pps_pkg::rsp_t rsp_data
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("request taken while response pending");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.run_valid) |-> (rsp_data.run_pid == '0 &&
		rsp_data.run_remaining == '0 && rsp_data.run_start == '0))
		else $error("idle result not cleared");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.queue_count <= 5'(pps_pkg::QUEUE_DEPTH))
		else $error("queue count overflow");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled response changed");

endmodule

bind preemptive_priority_scheduler pps_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

/* tb/tb_sched_sb.sv */
`timescale 1ns / 100ps

// Scheduler state mirror and result checking
package tb_sched_sb;
	import pps_pkg::*;

	class sched_scoreboard;
		entry_t       ready_q[$];
		logic         run_on;
		entry_t       run_rec;
		logic [31:0]  run_t0;
		rsp_t         pending[$];
		int           mismatches;

		function void clear();
			ready_q.delete();
			pending.delete();
			run_on = 1'b0;
			run_rec = '0;
			run_t0 = '0;
			mismatches = 0;
		endfunction

		// Work out the scheduler's reply to one accepted request
		function void note_request(req_t r);
			rsp_t        e;
			entry_t      fresh;
			logic [31:0] elapsed;
			int          best;
			e = '0;
			fresh.pid = r.new_pid;
			fresh.arrival = r.new_arrival;
			fresh.total = r.new_total_burst;
			fresh.remaining = r.new_total_burst;
			fresh.prio = r.new_priority;
			if (r.req_type == REQ_ARRIVAL) begin
				if (!run_on) begin
					run_on = 1'b1; run_rec = fresh; run_t0 = r.timestamp;
				end else if (r.new_priority >= run_rec.prio) begin
					if (ready_q.size() < QUEUE_DEPTH) ready_q.push_back(fresh);
					else e.dropped = 1'b1;
				end else begin
					if (ready_q.size() < QUEUE_DEPTH) begin
						elapsed = r.timestamp - run_t0;
						if ({16'd0, run_rec.remaining} > elapsed)
							run_rec.remaining = run_rec.remaining - elapsed[15:0];
						else
							run_rec.remaining = '0;
						ready_q.push_back(run_rec);
					end else e.dropped = 1'b1;
					run_rec = fresh; run_t0 = r.timestamp;
				end
			end else if (ready_q.size() == 0) begin
				run_on = 1'b0; run_rec = '0; run_t0 = '0;
			end else begin
				best = 0;
				for (int i = 1; i < ready_q.size(); i++)
					if (ready_q[i].prio < ready_q[best].prio) best = i;
				run_rec = ready_q[best];
				ready_q.delete(best);
				run_on = 1'b1; run_t0 = r.timestamp;
			end
			e.run_valid = run_on;
			if (run_on) begin
				e.run_pid = run_rec.pid;
				e.run_arrival = run_rec.arrival;
				e.run_total_burst = run_rec.total;
				e.run_start = run_t0;
				e.run_end = run_t0 + {16'd0, run_rec.remaining};
				e.run_remaining = run_rec.remaining;
				e.run_priority = run_rec.prio;
			end
			e.queue_count = 5'(ready_q.size());
			pending.push_back(e);
		endfunction

		function int queued();
			return ready_q.size();
		endfunction

		// Compare one reply with the oldest expectation
		function void check_reply(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected reply %h", got);
				return;
			end
			e = pending.pop_front();
			if (got.run_valid !== e.run_valid || got.run_pid !== e.run_pid ||
			    got.run_arrival !== e.run_arrival ||
			    got.run_total_burst !== e.run_total_burst ||
			    got.run_start !== e.run_start || got.run_end !== e.run_end ||
			    got.run_remaining !== e.run_remaining ||
			    got.run_priority !== e.run_priority ||
			    got.queue_count !== e.queue_count || got.dropped !== e.dropped) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply mismatch: expected %h actual %h", e, got);
			end
		endfunction
	endclass
endpackage

/* tb/tb_preemptive_priority_scheduler.sv */
`timescale 1ns / 100ps

module tb_preemptive_priority_scheduler;
	import pps_pkg::*;
	import tb_sched_sb::*;

	localparam int STALL_LIMIT = 5000;
	localparam int REQ_W = $bits(req_t);

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_cnt;
	int   sent;
	int   got;
	logic [31:0] now_t;
	sched_scoreboard sb;

	pps_req_if req_ch();
	pps_rsp_if rsp_ch();

	preemptive_priority_scheduler DUT (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample transactions at the rising edge
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			sb.note_request(req_ch.data);
			sent++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			sb.check_reply(rsp_ch.data);
			got++;
		end
		if (arst_n && !(req_ch.valid && req_ch.ready) && !(rsp_ch.valid && rsp_ch.ready)
		    && (sb.pending.size() > 0 || req_ch.valid)) begin
			stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end else stall_cnt = 0;
	end

	// Random back-pressure on the reply side
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	// Called at a falling edge; returns at the falling edge after the transaction
	task automatic send_req(req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.data <= r;
		req_ch.valid <= 1'b1;
		// ready only moves at rising edges, so it is settled here
		while (!req_ch.ready) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic arrive(logic [31:0] ts, logic [15:0] pid, logic [31:0] arr,
	                      logic [15:0] tot, logic [7:0] pr);
		req_t r;
		r.req_type = REQ_ARRIVAL;
		r.timestamp = ts; r.new_pid = pid; r.new_arrival = arr;
		r.new_total_burst = tot; r.new_priority = pr;
		send_req(r);
	endtask

	task automatic complete(logic [31:0] ts);
		req_t r;
		r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
		r.req_type = REQ_COMPLETE;
		r.timestamp = ts;
		send_req(r);
	endtask

	initial begin
		req_t r;
		int   n;
		sb = new();
		sb.clear();
		idle_pct = 13;
		stall_cnt = 0; sent = 0; got = 0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle completion, idle arrival, extremes, preemption, drops
		complete(32'd0);
		arrive(32'd100, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'd128);
		arrive(32'hFFFF_FFF0, 16'd0, 32'd0, 16'd0, 8'd255);
		arrive(32'd50, 16'h1234, 32'd7, 16'd10, 8'd0);
		arrive(32'd40, 16'h2222, 32'd8, 16'd20, 8'd0);
		for (int i = 0; i < 16; i++)
			arrive(32'd60 + i, i[15:0], 32'(i), 16'd5, 8'($urandom_range(255)));
		arrive(32'd90, 16'h3333, 32'd9, 16'd3, 8'd200);
		complete(32'hFFFF_FFFF);
		complete(32'd200);
		while (sb.queued() > 0) complete($urandom);
		complete(32'd300);

		// Random: arrivals with advancing time, completions and raw random requests
		now_t = $urandom;
		for (int k = 0; k < 1050; k++) begin
			idle_pct = (k >= 400 && k < 550) ? 0 : 13;
			now_t += $urandom_range(40);
			n = $urandom_range(99);
			if (n < 3) begin
				r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
				send_req(r);
			end else if (n < 55 || (sb.queued() >= QUEUE_DEPTH && n < 75)) begin
				arrive(($urandom_range(19) == 0) ? $urandom : now_t, 16'($urandom),
				       $urandom,
				       ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60)),
				       ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(7)));
			end else complete(now_t);
		end
		req_ch.valid <= 1'b0;

		while (sb.pending.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
